>>> design/wfd_pkg.sv
package wfd_pkg;

  typedef enum logic [5:0] {
    PhHead0   = 6'b000001,
    PhHead1   = 6'b000010,
    PhExtLen  = 6'b000100,
    PhMask    = 6'b001000,
    PhPayload = 6'b010000,
    PhHalted  = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    EvByte  = 2'd0,
    EvEmpty = 2'd1,
    EvError = 2'd2
  } event_e;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrOpcode = 2'd1;
  localparam logic [1:0] ErrLength = 2'd2;

  localparam logic [2:0] MsgText   = 3'd0;
  localparam logic [2:0] MsgBinary = 3'd1;
  localparam logic [2:0] MsgClose  = 3'd2;
  localparam logic [2:0] MsgPing   = 3'd3;
  localparam logic [2:0] MsgPong   = 3'd4;

  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  localparam logic [6:0]  Len16Code   = 7'd126;
  localparam logic [31:0] MaxLenReset = 32'd65536;

  typedef struct packed {
    event_e     kind;
    logic [7:0] data;
    logic [2:0] mtype;
    logic       fin;
    logic       last;
    logic [1:0] err;
  } result_t;

endpackage

>>> design/websocket_frame_decoder.sv
// WebSocket receive-side frame decoder. Takes one raw byte per cycle on the
// s_axis side and gives at most one item per byte on the m_axis side: an
// unmasked payload byte, an end mark for an empty frame, or a protocol error
// (reserved opcode, or payload length above max_frame_length). After an
// error every byte is taken and dropped until reset. Header, extended length
// and mask key bytes give only error or empty-frame items. Items are
// registered; a byte is accepted every cycle unless the output register
// holds an item that the sink stalls. The user writes max_frame_length
// (reset 65536) through cfg_we_i/cfg_wdata_i only while the stream is idle;
// the block does not enforce it. It is sampled when a frame's length is complete.
module websocket_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] final_fragment,
                                      // [10:9] error_code, [15:11] zero
  output logic        m_axis_tlast,   // last_of_frame
  output logic [4:0]  m_axis_tuser,   // [1:0] event_kind, [4:2] message_type
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import wfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic        masked_q, masked_d;
  logic [2:0]  cur_q, cur_d;
  logic [2:0]  held_q, held_d;
  logic [2:0]  count_q, count_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  off_q, off_d;
  logic [31:0] max_len_q;
  logic        out_valid_q;
  result_t     out_q, res;
  logic        res_valid;
  logic        fire;

  logic        len_done, start, masked_now, too_long;
  logic [63:0] len_full, start_len;
  logic [7:0]  key_byte;
  logic [7:0]  b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  assign len_full   = (phase_q == PhHead1) ? {57'd0, b[6:0]} : {rem_q[55:0], b};
  assign masked_now = (phase_q == PhHead1) ? b[7] : masked_q;
  assign too_long   = (|len_full[63:32]) || (len_full[31:0] > max_len_q);
  assign key_byte   = masked_q ? key_q[{~off_q, 3'b000} +: 8] : 8'd0;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    masked_d  = masked_q;
    cur_d     = cur_q;
    held_d    = held_q;
    count_d   = count_q;
    rem_d     = rem_q;
    key_d     = key_q;
    off_d     = off_q;
    res       = '0;
    res_valid = 1'b0;
    len_done  = 1'b0;
    start     = 1'b0;
    start_len = rem_q;

    case (phase_q)
      PhHead0: begin
        fin_d   = b[7];
        phase_d = PhHead1;
        case (b[3:0])
          OpText:   begin cur_d = MsgText;   held_d = MsgText;   end
          OpBinary: begin cur_d = MsgBinary; held_d = MsgBinary; end
          OpClose:  cur_d = MsgClose;
          OpPing:   cur_d = MsgPing;
          OpPong:   cur_d = MsgPong;
          OpCont:   cur_d = held_q;
          default: begin
            phase_d   = PhHalted;
            res_valid = 1'b1;
            res.kind  = EvError;
            res.last  = 1'b1;
            res.err   = ErrOpcode;
          end
        endcase
      end
      PhHead1: begin
        masked_d = b[7];
        rem_d    = '0;
        if (b[6:0] < Len16Code) begin
          len_done = 1'b1;
        end else begin
          count_d = (b[6:0] == Len16Code) ? 3'd1 : 3'd7;
          phase_d = PhExtLen;
        end
      end
      PhExtLen: begin
        rem_d = len_full;
        if (count_q == 3'd0) begin
          len_done = 1'b1;
        end else begin
          count_d = count_q - 3'd1;
        end
      end
      PhMask: begin
        key_d = {key_q[23:0], b};
        if (count_q == 3'd0) begin
          start = 1'b1;
        end else begin
          count_d = count_q - 3'd1;
        end
      end
      PhPayload: begin
        off_d     = off_q + 2'd1;
        rem_d     = rem_q - 64'd1;
        res_valid = 1'b1;
        res.kind  = EvByte;
        res.data  = b ^ key_byte;
        res.mtype = cur_q;
        res.fin   = fin_q;
        res.last  = (rem_q == 64'd1);
        if (rem_q == 64'd1) begin
          phase_d = PhHead0;
        end
      end
      default: begin
      end
    endcase

    if (len_done) begin
      rem_d     = len_full;
      start_len = len_full;
      if (too_long) begin
        phase_d   = PhHalted;
        res_valid = 1'b1;
        res.kind  = EvError;
        res.last  = 1'b1;
        res.err   = ErrLength;
      end else if (masked_now) begin
        phase_d = PhMask;
        count_d = 3'd3;
      end else begin
        start = 1'b1;
      end
    end

    if (start) begin
      off_d = 2'd0;
      if (start_len == 64'd0) begin
        phase_d   = PhHead0;
        res_valid = 1'b1;
        res.kind  = EvEmpty;
        res.mtype = cur_q;
        res.fin   = fin_q;
        res.last  = 1'b1;
      end else begin
        phase_d = PhPayload;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHead0;
      held_q      <= MsgText;
      max_len_q   <= MaxLenReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        held_q  <= held_d;
      end
      if (s_axis_tready) begin
        out_valid_q <= fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      fin_q    <= fin_d;
      masked_q <= masked_d;
      cur_q    <= cur_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      off_q    <= off_d;
    end
    if (s_axis_tready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.err, out_q.fin, out_q.data};
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = {out_q.mtype, out_q.kind};

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalted |=> phase_q == PhHalted)
    else $error("left halted phase before reset");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == PhHalted |=> !out_valid_q)
    else $error("item produced after error");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == EvError |-> out_q.last && out_q.err != ErrNone)
    else $error("error item without last or code");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != EvByte |-> out_q.data == 8'd0)
    else $error("nonzero data on non-payload item");

  a_err_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != EvError |-> out_q.err == ErrNone)
    else $error("error code on non-error item");

endmodule
